/* hw/rtl/tsgf_pkg.sv */
// ----------------------------------------------------------------------------
// tsgf_pkg
// Shared types and constants of the touch sample group filter.
// ----------------------------------------------------------------------------
package tsgf_pkg;

  localparam int FIELD_W  = 12;
  localparam int STATUS_W = 2;
  localparam int GROUPS   = 3;
  localparam int CNT_W    = 4;

  // last sample index of a full burst (nine samples, counted from zero)
  localparam logic [CNT_W-1:0] BURST_LAST = 4'd8;
  localparam logic [CNT_W-1:0] GRP1_START = 4'd3;
  localparam logic [CNT_W-1:0] GRP2_START = 4'd6;

  localparam logic [FIELD_W-1:0] THR_RESET = 12'd2;

  // floor(n / 3) = (n * 43691) >> 17, exact for n below 98304
  localparam int               DIV3_SHIFT = 17;
  localparam logic [16:0]      DIV3_MUL   = 17'd43691;

  typedef enum logic [STATUS_W-1:0] {
    ST_FILTERED  = 2'd0,
    ST_FIRST_RAW = 2'd1,
    ST_NOISY     = 2'd2,
    ST_TOO_FEW   = 2'd3
  } status_t;

  // what kind of burst a pipeline token carries
  typedef enum logic [1:0] {
    KIND_FULL,
    KIND_FIRST,
    KIND_FEW
  } kind_t;

  typedef struct packed {
    logic       accept;     // sample transaction this cycle
    logic       first;      // sample is the first of its burst
    logic [1:0] grp;        // group the sample belongs to
    logic       burst_end;  // sample closes the burst
    logic       s1_load;
    logic       s2_load;
    logic       s3_load;
  } lane_ctl_t;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] pos;
    logic [FIELD_W-1:0] first;
  } lane_res_t;

endpackage

/* hw/rtl/tsgf_if.sv */
// ----------------------------------------------------------------------------
// tsgf channel interfaces
// Valid/ready channels for samples, results and the threshold register.
// ----------------------------------------------------------------------------
interface tsgf_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsgf_pkg::FIELD_W-1:0]  x_sample;
  logic [tsgf_pkg::FIELD_W-1:0]  y_sample;
  logic                          pen_up;

  modport source (output valid, output x_sample, output y_sample, output pen_up,
                  input ready);
  modport sink   (input valid, input x_sample, input y_sample, input pen_up,
                  output ready);
endinterface

interface tsgf_out_if;
  logic                          valid;
  logic                          ready;
  logic [tsgf_pkg::FIELD_W-1:0]  x_pos;
  logic [tsgf_pkg::FIELD_W-1:0]  y_pos;
  logic [tsgf_pkg::STATUS_W-1:0] status;

  modport source (output valid, output x_pos, output y_pos, output status,
                  input ready);
  modport sink   (input valid, input x_pos, input y_pos, input status,
                  output ready);
endinterface

interface tsgf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tsgf_pkg::FIELD_W-1:0]  noise_threshold;

  modport source (output valid, output noise_threshold, input ready);
  modport sink   (input valid, input noise_threshold, output ready);
endinterface

/* hw/rtl/tsgf_axis_lane.sv */
// ----------------------------------------------------------------------------
// tsgf_axis_lane
// One axis: group accumulation, then a three stage average / pick pipeline.
// ----------------------------------------------------------------------------
module tsgf_axis_lane #(
  parameter int SAMPLE_W = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsgf_pkg::lane_ctl_t           ctl,
  input  logic [tsgf_pkg::FIELD_W-1:0]  sample,
  input  logic [tsgf_pkg::FIELD_W-1:0]  thr,
  output tsgf_pkg::lane_res_t           res
);

  localparam int SUM_W  = SAMPLE_W + 2;
  localparam int PROD_W = SUM_W + 17;
  localparam int G      = tsgf_pkg::GROUPS;

  logic [SAMPLE_W-1:0] smp;
  logic [SUM_W-1:0]    sum_r [G];
  logic [SUM_W-1:0]    sum_nxt [G];
  logic [SUM_W-1:0]    snap [G];
  logic [SAMPLE_W-1:0] first_r;

  logic [SUM_W-1:0]    s1_sum_r [G];
  logic [SAMPLE_W-1:0] s1_first_r;
  logic [PROD_W-1:0]   prod [G];
  logic [SAMPLE_W-1:0] s2_avg_r [G];
  logic [SAMPLE_W-1:0] s2_first_r;
  logic [SAMPLE_W-1:0] s3_avg_r [G];
  logic [SAMPLE_W-1:0] s3_d_r [G];   // d01, d12, d20
  logic [SAMPLE_W-1:0] s3_first_r;
  logic [SAMPLE_W-1:0] dif [G];

  logic                over01, over12, over20;
  logic                lt_01_12, lt_20_01, lt_20_12;
  logic [SAMPLE_W-1:0] pa, pb;
  logic [SAMPLE_W:0]   pair_sum;

  // bits above the converter width are ignored
  assign smp = sample[SAMPLE_W-1:0];

  always_comb begin
    for (int g = 0; g < G; g++) begin
      snap[g] = sum_r[g];
      if (ctl.grp == 2'(g)) begin
        snap[g] = sum_r[g] + SUM_W'(smp);
      end
      if (ctl.burst_end) begin
        sum_nxt[g] = '0;
      end else if (ctl.accept) begin
        sum_nxt[g] = snap[g];
      end else begin
        sum_nxt[g] = sum_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < G; g++) begin
        sum_r[g] <= '0;
      end
    end else begin
      for (int g = 0; g < G; g++) begin
        sum_r[g] <= sum_nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && ctl.first) begin
      first_r <= smp;
    end
  end

  // stage 1: snapshot of the finished burst
  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      for (int g = 0; g < G; g++) begin
        s1_sum_r[g] <= snap[g];
      end
      s1_first_r <= first_r;
    end
  end

  // stage 2: group averages by reciprocal multiply
  always_comb begin
    for (int g = 0; g < G; g++) begin
      prod[g] = PROD_W'(s1_sum_r[g]) * PROD_W'(tsgf_pkg::DIV3_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      for (int g = 0; g < G; g++) begin
        s2_avg_r[g] <= prod[g][tsgf_pkg::DIV3_SHIFT +: SAMPLE_W];
      end
      s2_first_r <= s1_first_r;
    end
  end

  // stage 3: pairwise distances
  always_comb begin
    for (int g = 0; g < G; g++) begin
      if (s2_avg_r[g] > s2_avg_r[(g + 1) % G]) begin
        dif[g] = s2_avg_r[g] - s2_avg_r[(g + 1) % G];
      end else begin
        dif[g] = s2_avg_r[(g + 1) % G] - s2_avg_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_load) begin
      for (int g = 0; g < G; g++) begin
        s3_avg_r[g] <= s2_avg_r[g];
        s3_d_r[g]   <= dif[g];
      end
      s3_first_r <= s2_first_r;
    end
  end

  // reject test and closest pair selection
  always_comb begin
    over01   = tsgf_pkg::FIELD_W'(s3_d_r[0]) > thr;
    over12   = tsgf_pkg::FIELD_W'(s3_d_r[1]) > thr;
    over20   = tsgf_pkg::FIELD_W'(s3_d_r[2]) > thr;
    lt_01_12 = s3_d_r[0] < s3_d_r[1];
    lt_20_01 = s3_d_r[2] < s3_d_r[0];
    lt_20_12 = s3_d_r[2] < s3_d_r[1];
    if (lt_01_12) begin
      pa = s3_avg_r[0];
      pb = lt_20_01 ? s3_avg_r[2] : s3_avg_r[1];
    end else if (lt_20_12) begin
      pa = s3_avg_r[0];
      pb = s3_avg_r[2];
    end else begin
      pa = s3_avg_r[1];
      pb = s3_avg_r[2];
    end
    pair_sum  = (SAMPLE_W + 1)'(pa) + (SAMPLE_W + 1)'(pb);
    res.ok    = !(over01 && over12 && over20);
    res.pos   = tsgf_pkg::FIELD_W'(pair_sum[SAMPLE_W:1]);
    res.first = tsgf_pkg::FIELD_W'(s3_first_r);
  end

endmodule

/* hw/rtl/tsgf_merge.sv */
// ----------------------------------------------------------------------------
// tsgf_merge
// Combines both axis lanes into one result and holds the output register.
// ----------------------------------------------------------------------------
module tsgf_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s3_valid,
  input  tsgf_pkg::kind_t       s3_kind,
  input  tsgf_pkg::lane_res_t   res_x,
  input  tsgf_pkg::lane_res_t   res_y,
  output logic                  out_free,
  tsgf_out_if.source            out_ch
);

  logic                          out_v_r;
  logic                          out_v_nxt;
  logic                          load;
  logic [tsgf_pkg::FIELD_W-1:0]  x_nxt, y_nxt, x_r, y_r;
  tsgf_pkg::status_t             st_nxt, st_r;

  assign out_free  = !out_v_r || out_ch.ready;
  assign load      = s3_valid && out_free;
  assign out_v_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  always_comb begin
    x_nxt  = '0;
    y_nxt  = '0;
    st_nxt = tsgf_pkg::ST_TOO_FEW;
    case (s3_kind)
      tsgf_pkg::KIND_FULL: begin
        // x and y are checked together, and either failing rejects the burst
        if (res_x.ok && res_y.ok) begin
          x_nxt  = res_x.pos;
          y_nxt  = res_y.pos;
          st_nxt = tsgf_pkg::ST_FILTERED;
        end else begin
          st_nxt = tsgf_pkg::ST_NOISY;
        end
      end
      tsgf_pkg::KIND_FIRST: begin
        x_nxt  = res_x.first;
        y_nxt  = res_y.first;
        st_nxt = tsgf_pkg::ST_FIRST_RAW;
      end
      default: begin
        st_nxt = tsgf_pkg::ST_TOO_FEW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.x_pos  = x_r;
  assign out_ch.y_pos  = y_r;
  assign out_ch.status = st_r;

endmodule

/* hw/rtl/touch_sample_group_filter_top.sv */
// ----------------------------------------------------------------------------
// touch_sample_group_filter_top
// Burst filter for touch panel ADC sample pairs with noise rejection.
// ----------------------------------------------------------------------------
// in_ch takes one (x_sample, y_sample, pen_up) transaction per cycle while
// ready. A burst closes on pen_up or on its ninth sample; only then one
// transaction leaves on out_ch with x_pos, y_pos and status (filtered,
// first raw, noisy, too few). cfg_ch writes noise_threshold and is always
// ready; write it only while no burst is in flight.
// Throughput: one sample per cycle while in_ch is ready. X and Y run in
// two identical lanes that keep three group sums each; a closing sample
// launches a token into a three stage pipeline per lane (snapshot, divide
// by three, distances) and the merge stage forms the result in the output
// register. The closing sample loads the snapshot stage, and its result
// passes the average and distance stages into the output register.
// Stalls: the snapshot, average, distance and output stages form an elastic
// chain, so in_ch stays ready until all four hold a waiting result.
// Reset: clears the sample counter, group sums and all valid flags, and
// sets noise_threshold to 2.
// ----------------------------------------------------------------------------
module touch_sample_group_filter_top #(
  parameter int ADC_WIDTH = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  tsgf_in_if.sink    in_ch,
  tsgf_out_if.source out_ch,
  tsgf_cfg_if.sink   cfg_ch
);

  localparam int SAMPLE_W = (ADC_WIDTH > tsgf_pkg::FIELD_W) ? tsgf_pkg::FIELD_W
                                                            : ADC_WIDTH;

  logic [tsgf_pkg::FIELD_W-1:0] thr_r;
  logic [tsgf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         accept, burst_end;
  logic                         s1_v_r, s2_v_r, s3_v_r;
  logic                         s1_v_nxt, s2_v_nxt, s3_v_nxt;
  logic                         s1_adv, s2_adv, s3_adv;
  logic                         s1_free, s2_free, s3_free;
  logic                         out_free;
  tsgf_pkg::kind_t              kind_nxt, s1_kind_r, s2_kind_r, s3_kind_r;
  tsgf_pkg::lane_ctl_t          ctl;
  tsgf_pkg::lane_res_t          res_x, res_y;

  // elastic chain: a stage moves on when the one after it has room
  assign s3_adv  = s3_v_r && out_free;
  assign s3_free = !s3_v_r || s3_adv;
  assign s2_adv  = s2_v_r && s3_free;
  assign s2_free = !s2_v_r || s2_adv;
  assign s1_adv  = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || s1_adv;

  assign in_ch.ready = s1_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign burst_end   = accept && (in_ch.pen_up || (cnt_r == tsgf_pkg::BURST_LAST));

  assign s1_v_nxt = burst_end ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign s2_v_nxt = s1_adv    ? 1'b1 : (s2_adv ? 1'b0 : s2_v_r);
  assign s3_v_nxt = s2_adv    ? 1'b1 : (s3_adv ? 1'b0 : s3_v_r);

  always_comb begin
    if (burst_end) begin
      cnt_nxt = '0;
    end else if (accept) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
    if (cnt_r == tsgf_pkg::BURST_LAST) begin
      kind_nxt = tsgf_pkg::KIND_FULL;
    end else if (cnt_r != '0) begin
      kind_nxt = tsgf_pkg::KIND_FIRST;
    end else begin
      kind_nxt = tsgf_pkg::KIND_FEW;
    end
  end

  always_comb begin
    ctl.accept    = accept;
    ctl.first     = (cnt_r == '0);
    ctl.burst_end = burst_end;
    ctl.s1_load   = burst_end;
    ctl.s2_load   = s1_adv;
    ctl.s3_load   = s2_adv;
    if (cnt_r < tsgf_pkg::GRP1_START) begin
      ctl.grp = 2'd0;
    end else if (cnt_r < tsgf_pkg::GRP2_START) begin
      ctl.grp = 2'd1;
    end else begin
      ctl.grp = 2'd2;
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= tsgf_pkg::THR_RESET;
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        thr_r <= cfg_ch.noise_threshold;
      end
      cnt_r  <= cnt_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_end) begin
      s1_kind_r <= kind_nxt;
    end
    if (s1_adv) begin
      s2_kind_r <= s1_kind_r;
    end
    if (s2_adv) begin
      s3_kind_r <= s2_kind_r;
    end
  end

  tsgf_axis_lane #(.SAMPLE_W(SAMPLE_W)) u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_ch.x_sample),
    .thr    (thr_r),
    .res    (res_x)
  );

  tsgf_axis_lane #(.SAMPLE_W(SAMPLE_W)) u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_ch.y_sample),
    .thr    (thr_r),
    .res    (res_y)
  );

  tsgf_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .s3_valid (s3_v_r),
    .s3_kind  (s3_kind_r),
    .res_x    (res_x),
    .res_y    (res_y),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    burst_end |=> (cnt_r == '0))
    else $error("sample counter not cleared after burst end");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !burst_end) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("sample counter did not advance");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tsgf_pkg::BURST_LAST)
    else $error("sample counter beyond a full burst");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && s2_v_r && s3_v_r && out_ch.valid && !out_ch.ready))
    else $error("input stalled while the pipeline has room");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> s1_v_r)
    else $error("snapshot token lost");

endmodule

/* sim/tb_touch_sample_group_filter_top.sv */
// ----------------------------------------------------------------------------
// tb_touch_sample_group_filter_top
// Self-checking bench for the touch sample group filter. Bursts of samples
// are sent on in_ch. A scoreboard models the group sums and the pair
// selection, and checks each result transaction against it. Bursts are
// mostly well-formed nine-sample groups, with short bursts and random noise
// mixed in. The run goes through several noise thresholds, and both sides
// stall at random.
// ----------------------------------------------------------------------------
module tb_touch_sample_group_filter_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 155;
  localparam int DRAIN_CYCLES = 6;

  typedef struct {
    logic [tsgf_pkg::FIELD_W-1:0] x_pos;
    logic [tsgf_pkg::FIELD_W-1:0] y_pos;
    tsgf_pkg::status_t            status;
  } touch_result_t;

  class touch_burst_scoreboard;
    logic [tsgf_pkg::FIELD_W-1:0] thr;
    logic [tsgf_pkg::CNT_W-1:0]   count;
    logic [tsgf_pkg::FIELD_W-1:0] first_x;
    logic [tsgf_pkg::FIELD_W-1:0] first_y;
    logic [13:0]                  sum_x [3];
    logic [13:0]                  sum_y [3];
    touch_result_t                pending [$];
    int                           errors;

    function void reset_state();
      thr     = tsgf_pkg::THR_RESET;
      first_x = '0;
      first_y = '0;
      clear_burst();
    endfunction

    function void clear_burst();
      count = '0;
      for (int g = 0; g < tsgf_pkg::GROUPS; g++) begin
        sum_x[g] = '0;
        sum_y[g] = '0;
      end
    endfunction

    // returns 0 when every group-average distance exceeds the threshold
    function bit axis_pos(input logic [13:0] sums [3],
                          output logic [tsgf_pkg::FIELD_W-1:0] pos);
      logic [tsgf_pkg::FIELD_W-1:0] a0, a1, a2, d01, d12, d20;
      logic [tsgf_pkg::FIELD_W:0]   pair;
      a0  = tsgf_pkg::FIELD_W'(sums[0] / 3);
      a1  = tsgf_pkg::FIELD_W'(sums[1] / 3);
      a2  = tsgf_pkg::FIELD_W'(sums[2] / 3);
      d01 = (a0 > a1) ? a0 - a1 : a1 - a0;
      d12 = (a1 > a2) ? a1 - a2 : a2 - a1;
      d20 = (a2 > a0) ? a2 - a0 : a0 - a2;
      pos = '0;
      if (d01 > thr && d12 > thr && d20 > thr) return 1'b0;
      if (d01 < d12) begin
        pair = (d20 < d01) ? a0 + a2 : a0 + a1;
      end else begin
        pair = (d20 < d12) ? a0 + a2 : a1 + a2;
      end
      pos = pair[tsgf_pkg::FIELD_W:1];
      return 1'b1;
    endfunction

    function void note_sample(logic [tsgf_pkg::FIELD_W-1:0] x,
                              logic [tsgf_pkg::FIELD_W-1:0] y, logic up);
      int            g;
      touch_result_t r;
      g = (count / 3 > 2) ? 2 : count / 3;
      if (count == 0) begin
        first_x = x;
        first_y = y;
      end
      sum_x[g] += x;
      sum_y[g] += y;
      count++;
      if (!up && count <= tsgf_pkg::BURST_LAST) return;
      if (count > tsgf_pkg::BURST_LAST) begin
        if (axis_pos(sum_x, r.x_pos) && axis_pos(sum_y, r.y_pos)) begin
          r.status = tsgf_pkg::ST_FILTERED;
        end else begin
          r.x_pos  = '0;
          r.y_pos  = '0;
          r.status = tsgf_pkg::ST_NOISY;
        end
      end else if (count > 1) begin
        r.x_pos  = first_x;
        r.y_pos  = first_y;
        r.status = tsgf_pkg::ST_FIRST_RAW;
      end else begin
        r.x_pos  = '0;
        r.y_pos  = '0;
        r.status = tsgf_pkg::ST_TOO_FEW;
      end
      pending.push_back(r);
      clear_burst();
    endfunction

    function void check_result(logic [tsgf_pkg::FIELD_W-1:0] x,
                               logic [tsgf_pkg::FIELD_W-1:0] y,
                               logic [tsgf_pkg::STATUS_W-1:0] st);
      touch_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got x=%0d y=%0d status=%0d",
                 $time, x, y, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x_pos) begin
        $display("%0t: x_pos mismatch, expected %0d, got %0d", $time, e.x_pos, x);
        errors++;
      end
      if (y !== e.y_pos) begin
        $display("%0t: y_pos mismatch, expected %0d, got %0d", $time, e.y_pos, y);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_en;
  int   sent_items;
  int   cycles;
  int   stall_left;
  touch_burst_scoreboard sb;

  tsgf_in_if  in_ch ();
  tsgf_out_if out_ch ();
  tsgf_cfg_if cfg_ch ();

  touch_sample_group_filter_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stall bursts while idling is enabled
  initial begin
    stall_left   = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.x_pos, out_ch.y_pos, out_ch.status);
  end

  function automatic logic [tsgf_pkg::FIELD_W-1:0] clamp12(int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'hfff;
    return tsgf_pkg::FIELD_W'(v);
  endfunction

  function automatic logic [tsgf_pkg::FIELD_W-1:0] rand_sample();
    return tsgf_pkg::FIELD_W'($urandom_range(0, 4095));
  endfunction

  task automatic send_sample(logic [tsgf_pkg::FIELD_W-1:0] x,
                             logic [tsgf_pkg::FIELD_W-1:0] y, logic up);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.x_sample <= x;
    in_ch.y_sample <= y;
    in_ch.pen_up   <= up;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(x, y, up);
    sent_items++;
    @(negedge clk);
  endtask

  // nine samples, three per group around the given centers
  task automatic send_groups(input int cx [3], input int cy [3], input int jit,
                             input bit up_last);
    for (int g = 0; g < tsgf_pkg::GROUPS; g++) begin
      for (int k = 0; k < 3; k++) begin
        send_sample(clamp12(cx[g] + int'($urandom_range(0, jit))),
                    clamp12(cy[g] + int'($urandom_range(0, jit))),
                    (g == 2 && k == 2) ? up_last : 1'b0);
      end
    end
  endtask

  function automatic void pick_centers(output int c [3]);
    int base, s, p, o;
    base = $urandom_range(0, 4095);
    s    = $urandom_range(0, 2 * int'(sb.thr) + 4);
    if (s > 1365) s = $urandom_range(0, 1365);
    p = $urandom_range(0, 3);
    o = $urandom_range(0, 2);
    for (int g = 0; g < tsgf_pkg::GROUPS; g++) begin
      case (p)
        0: begin
          c[g] = base + int'($urandom_range(0, s)) - s / 2;
        end
        1: begin
          c[g] = (g == o) ? base + ($urandom_range(0, 1) ? s : -s)
                          : base + int'($urandom_range(0, 1));
        end
        2: begin
          // even spacing gives equal distances between neighbors
          c[g] = base + ((g + o) % 3) * s;
        end
        default: begin
          c[g] = $urandom_range(0, 4095);
        end
      endcase
    end
  endfunction

  task automatic send_random_burst();
    int mode, len;
    int cx [3];
    int cy [3];
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        send_sample(rand_sample(), rand_sample(), i == len - 1);
    end else if (mode == 9) begin
      // loose samples, bursts end wherever pen_up happens to fall
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
        send_sample(rand_sample(), rand_sample(), $urandom_range(0, 3) == 0);
    end else begin
      pick_centers(cx);
      pick_centers(cy);
      send_groups(cx, cy, $urandom_range(0, 1) * 2, 1'($urandom_range(0, 1)));
    end
  endtask

  // close any open burst and wait out every result before a register write
  task automatic drain();
    if (sb.count != 0) send_sample(rand_sample(), rand_sample(), 1'b1);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(logic [tsgf_pkg::FIELD_W-1:0] v);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.noise_threshold <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.thr = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int thr_list [PHASES];
    int phase_start;

    sb = new;
    sb.reset_state();
    sb.errors              = 0;
    idle_en                = 1'b1;
    sent_items             = 0;
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.x_sample         = '0;
    in_ch.y_sample         = '0;
    in_ch.pen_up           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.noise_threshold = '0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single sample burst, too few
    send_sample(12'hfff, 12'h000, 1'b1);
    // two samples, first raw returned
    send_sample(12'h000, 12'hfff, 1'b0);
    send_sample(12'd123, 12'd456, 1'b1);
    // quiet full burst at the extremes, closed by count alone
    send_groups('{4095, 4094, 4095}, '{0, 1, 0}, 0, 1'b0);
    // noisy on x, y quiet
    send_groups('{0, 2000, 4095}, '{1000, 1001, 1002}, 0, 1'b1);
    drain();

    thr_list = '{0, 4095, 1, $urandom_range(3, 40), $urandom_range(0, 4095), 2};
    for (int p = 0; p < PHASES; p++) begin
      idle_en = (p != PHASES - 1);
      write_threshold(tsgf_pkg::FIELD_W'(thr_list[p]));
      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS) send_random_burst();
      drain();
    end

    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/tsgf_pkg.sv
hw/rtl/tsgf_if.sv
hw/rtl/tsgf_axis_lane.sv
hw/rtl/tsgf_merge.sv
hw/rtl/touch_sample_group_filter_top.sv
sim/tb_touch_sample_group_filter_top.sv
